// ===== hw/rtl/tdnw_pkg.sv =====
`default_nettype none

package tdnw_pkg;

    // Field widths fixed by the pin and result formats
    localparam int OFFSET_BITS = 16;
    localparam int DIE_BITS    = 2;
    localparam int LEN_BITS    = 25;
    localparam int SUM_BITS    = 48;

    // Empty-box sentinels and the signed width that holds them
    localparam int MAX_SENTINEL = -2000000;
    localparam int MIN_SENTINEL = 20000000;
    localparam int SENT_BITS    = 26;

    typedef logic [DIE_BITS-1:0] t_die;

    localparam t_die DIE_BOTTOM = 2'd0;
    localparam t_die DIE_TOP    = 2'd1;
    localparam t_die DIE_BOTH   = 2'd2;
    localparam t_die DIE_NONE   = 2'd3;

endpackage

`default_nettype wire

// ===== hw/rtl/two_die_net_wirelength.sv =====
// Half-perimeter wirelength of nets split over two stacked dies.
//
// Input channel (i_in_valid / o_in_ready): one pin per transaction, with its
// cell position, signed pin offset, die code and a flag on the net's last pin.
// Pins of a net arrive back to back; one per cycle while o_in_ready is high.
// Output channel (o_out_valid / i_out_ready): one transaction per net, sent
// for its last pin, carrying the bottom and top half-perimeters and the three
// saturating running totals.
// The result passes five register stages (pin position, box update, axis
// spans, per-die length, length sum) and then the output register that
// applies the total update.
// Throughput: one pin per cycle while o_in_ready is high.
// Stall: while a result waits at the output, pins keep flowing until the next
// result reaches the last stage; only then does the pipeline hold with
// o_in_ready low, and it advances again in the cycle the waiting one is taken.
// Reset: both die boxes return to their empty sentinels, the totals to zero,
// and all pipeline stages drain.
`default_nettype none

module two_die_net_wirelength #(
    parameter int COORD_BITS = 23
) (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    input  wire                                     i_in_valid,
    output logic                                    o_in_ready,
    input  wire  [COORD_BITS-1:0]                   i_cell_x,
    input  wire  [COORD_BITS-1:0]                   i_cell_y,
    input  wire  signed [tdnw_pkg::OFFSET_BITS-1:0] i_offset_x,
    input  wire  signed [tdnw_pkg::OFFSET_BITS-1:0] i_offset_y,
    input  wire  tdnw_pkg::t_die                    i_die_code,
    input  wire                                     i_last_pin,
    output logic                                    o_out_valid,
    input  wire                                     i_out_ready,
    output logic [tdnw_pkg::LEN_BITS-1:0]           o_net_len_bottom,
    output logic [tdnw_pkg::LEN_BITS-1:0]           o_net_len_top,
    output logic [tdnw_pkg::SUM_BITS-1:0]           o_sum_bottom,
    output logic [tdnw_pkg::SUM_BITS-1:0]           o_sum_top,
    output logic [tdnw_pkg::SUM_BITS-1:0]           o_sum_both
);
    import tdnw_pkg::*;

    // Signed width covering pin positions and both sentinels
    localparam int BOX_BITS  = (COORD_BITS + 2 > SENT_BITS) ? COORD_BITS + 2 : SENT_BITS;
    // A span is non-negative and fits one bit less
    localparam int SPAN_BITS = BOX_BITS - 1;

    typedef logic signed [BOX_BITS-1:0] t_coord;

    typedef struct packed {
        t_coord max_x;
        t_coord max_y;
        t_coord min_x;
        t_coord min_y;
    } t_box;

    localparam t_coord MAX_INIT = BOX_BITS'(MAX_SENTINEL);
    localparam t_coord MIN_INIT = BOX_BITS'(MIN_SENTINEL);
    localparam t_box   BOX_INIT = '{MAX_INIT, MAX_INIT, MIN_INIT, MIN_INIT};

    function automatic t_box f_grow(input t_box b, input t_coord x, input t_coord y);
        t_box g;
        g = b;
        if (x > b.max_x) g.max_x = x;
        if (y > b.max_y) g.max_y = y;
        if (x < b.min_x) g.min_x = x;
        if (y < b.min_y) g.min_y = y;
        return g;
    endfunction

    function automatic logic [SPAN_BITS-1:0] f_span(input t_coord hi, input t_coord lo);
        t_coord diff;
        diff = hi - lo;
        // An axis counts only when its max is above zero
        if (!hi[BOX_BITS-1] && (hi != '0)) begin
            return diff[SPAN_BITS-1:0];
        end
        return '0;
    endfunction

    logic w_en;

    // Stage 1: pin position
    logic   r_v1;
    t_coord r_px;
    t_coord r_py;
    t_die   r_die;
    logic   r_last;
    t_coord n_px;
    t_coord n_py;

    // Stage 2: closed boxes of a finished net
    t_box   r_box [2];
    t_box   r_cb  [2];
    t_box   n_grown [2];
    logic   w_hit [2];
    logic   r_v2;

    // Stage 3: axis spans
    logic                 r_v3;
    logic [SPAN_BITS-1:0] r_dx [2];
    logic [SPAN_BITS-1:0] r_dy [2];

    // Stage 4: saturated per-die length
    logic                r_v4;
    logic [LEN_BITS-1:0] r_len [2];
    logic [SPAN_BITS:0]  n_sum [2];
    logic [LEN_BITS-1:0] n_len [2];

    // Stage 5: lengths and their sum
    logic                r_v5;
    logic [LEN_BITS-1:0] r_len5 [2];
    logic [LEN_BITS:0]   r_lsum;

    // Output stage
    logic                r_ovld;
    logic [LEN_BITS-1:0] r_olen [2];
    logic [SUM_BITS-1:0] r_tot_bottom;
    logic [SUM_BITS-1:0] r_tot_top;
    logic [SUM_BITS-1:0] r_tot_all;
    logic [SUM_BITS:0]   n_add_bottom;
    logic [SUM_BITS:0]   n_add_top;
    logic [SUM_BITS:0]   n_add_all;

    // Hold only when a second result would land on a waiting one
    assign w_en       = !r_v5 || !r_ovld || i_out_ready;
    assign o_in_ready = w_en;

    assign n_px = t_coord'(BOX_BITS'(i_cell_x)) + BOX_BITS'(i_offset_x);
    assign n_py = t_coord'(BOX_BITS'(i_cell_y)) + BOX_BITS'(i_offset_y);

    always_comb begin
        w_hit[0] = r_die inside {DIE_BOTTOM, DIE_BOTH};
        w_hit[1] = r_die inside {DIE_TOP, DIE_BOTH};
        for (int d = 0; d < 2; d++) begin
            n_grown[d] = w_hit[d] ? f_grow(r_box[d], r_px, r_py) : r_box[d];
            n_sum[d]   = {1'b0, r_dx[d]} + {1'b0, r_dy[d]};
            n_len[d]   = (|n_sum[d][SPAN_BITS:LEN_BITS]) ? '1 : n_sum[d][LEN_BITS-1:0];
        end
    end

    assign n_add_bottom = {1'b0, r_tot_bottom} + (SUM_BITS + 1)'(r_len5[0]);
    assign n_add_top    = {1'b0, r_tot_top} + (SUM_BITS + 1)'(r_len5[1]);
    assign n_add_all    = {1'b0, r_tot_all} + (SUM_BITS + 1)'(r_lsum);

    // Control and state that reset clears
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            r_v3         <= 1'b0;
            r_v4         <= 1'b0;
            r_v5         <= 1'b0;
            r_ovld       <= 1'b0;
            r_box[0]     <= BOX_INIT;
            r_box[1]     <= BOX_INIT;
            r_tot_bottom <= '0;
            r_tot_top    <= '0;
            r_tot_all    <= '0;
        end else begin
            if (w_en) begin
                r_v1 <= i_in_valid;
                r_v2 <= r_v1 && r_last;
                r_v3 <= r_v2;
                r_v4 <= r_v3;
                r_v5 <= r_v4;
                if (r_v1) begin
                    for (int d = 0; d < 2; d++) begin
                        // Close the net: drop back to empty boxes
                        r_box[d] <= r_last ? BOX_INIT : n_grown[d];
                    end
                end
            end
            if (w_en && r_v5) begin
                r_ovld <= 1'b1;
                // Saturate on carry out of the total
                r_tot_bottom <= n_add_bottom[SUM_BITS] ? '1 : n_add_bottom[SUM_BITS-1:0];
                r_tot_top    <= n_add_top[SUM_BITS] ? '1 : n_add_top[SUM_BITS-1:0];
                r_tot_all    <= n_add_all[SUM_BITS] ? '1 : n_add_all[SUM_BITS-1:0];
            end else if (i_out_ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    // Payload, advanced with the pipeline
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_px   <= n_px;
            r_py   <= n_py;
            r_die  <= i_die_code;
            r_last <= i_last_pin;
            for (int d = 0; d < 2; d++) begin
                r_cb[d]   <= n_grown[d];
                r_dx[d]   <= f_span(r_cb[d].max_x, r_cb[d].min_x);
                r_dy[d]   <= f_span(r_cb[d].max_y, r_cb[d].min_y);
                r_len[d]  <= n_len[d];
                r_len5[d] <= r_len[d];
            end
            r_lsum <= {1'b0, r_len[0]} + {1'b0, r_len[1]};
        end
        if (w_en && r_v5) begin
            for (int d = 0; d < 2; d++) begin
                r_olen[d] <= r_len5[d];
            end
        end
    end

    assign o_out_valid      = r_ovld;
    assign o_net_len_bottom = r_olen[0];
    assign o_net_len_top    = r_olen[1];
    assign o_sum_bottom     = r_tot_bottom;
    assign o_sum_top        = r_tot_top;
    assign o_sum_both       = r_tot_all;

endmodule

`default_nettype wire
